// ===== rtl/core/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, a, c, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) else $error(msg);
`define ASSERT_NEXT(label, a, c, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/core/sknsi_pkg.sv =====
package sknsi_pkg;
    localparam int MaxEntries = 64;
    localparam int KeyBytes   = 8;
    localparam logic CmdFind   = 1'b0;
    localparam logic CmdInsert = 1'b1;
    localparam logic StatOk    = 1'b0;
    localparam logic StatFull  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_PROBE, S_CMP, S_SRD, S_SWR, S_PLACE, S_DONE
    } t_state;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

    function automatic logic [63:0] prefix_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
            if (4'(b) < n) m[63 - 8 * b -: 8] = 8'hFF;
        return m;
    endfunction
endpackage

// ===== rtl/core/sknsi_ram.sv =====
module sknsi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/sknsi_cmp.sv =====
module sknsi_cmp (
    input  logic [63:0]       i_skey,
    input  logic [3:0]        i_slen,
    input  logic [63:0]       i_qkey,
    input  logic [3:0]        i_qlen,
    output sknsi_pkg::t_cmp   o_cmp
);
    logic [3:0]  n;
    logic [63:0] m, a, b;
    always_comb begin
        n = (i_slen < i_qlen) ? i_slen : i_qlen;
        m = sknsi_pkg::prefix_mask(n);
        a = i_skey & m;
        b = i_qkey & m;
        o_cmp.lt = (a < b) || (a == b && i_slen < i_qlen);
        o_cmp.eq = (a == b) && (i_slen == i_qlen);
    end
endmodule

// ===== rtl/core/sorted_key_node_search_insert.sv =====
// channel | ports                                             | handshake
// command | i_command i_key_bytes i_key_length i_new_value    | i_start & !o_busy
// result  | o_found o_entry_index o_stored_value o_status     | o_done, one cycle
// A find runs up to log2(count)+1 probes, each a RAM read then a compare.
// An insert then shifts each later entry up one slot, a read then a write
// per entry. Sync reset empties the node; stores need no clear.
// Results cannot be stalled.
module sorted_key_node_search_insert #(
    parameter int MAX_ENTRIES = sknsi_pkg::MaxEntries,
    parameter int KEY_BYTES   = sknsi_pkg::KeyBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_command,
    input  logic [63:0] i_key_bytes,
    input  logic [3:0]  i_key_length,
    input  logic [63:0] i_new_value,
    output logic        o_done,
    output logic        o_found,
    output logic [6:0]  o_entry_index,
    output logic [63:0] o_stored_value,
    output logic        o_status
);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = CW + 1;

    sknsi_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic          r_cmd;
    logic [63:0]   r_key, r_val;
    logic [3:0]    r_len;
    logic [PW-1:0] r_lo, r_hi, n_lo, n_hi;
    logic [CW-1:0] r_ptr;
    logic          r_found;
    logic          r_done;

    logic [3:0]  len_sat;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0] wkey, wval, rkey, rval;
    logic [3:0]  wlen, rlen;
    logic [PW-1:0] mid;
    sknsi_pkg::t_cmp cmp;

    assign len_sat = (i_key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : i_key_length;
    assign mid = r_lo + ((r_hi - r_lo) >> 1);

    sknsi_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_key (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wkey), .i_raddr(raddr), .o_rdata(rkey));
    sknsi_ram #(.WIDTH(4), .DEPTH(MAX_ENTRIES)) u_len (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wlen), .i_raddr(raddr), .o_rdata(rlen));
    sknsi_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_val (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wval), .i_raddr(raddr), .o_rdata(rval));

    sknsi_cmp u_cmp (.i_skey(rkey), .i_slen(rlen), .i_qkey(r_key), .i_qlen(r_len),
        .o_cmp(cmp));

    // lo/hi kept offset by one so hi never goes negative
    logic search_end;
    assign search_end = (r_lo > r_hi);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sknsi_pkg::S_IDLE:  if (i_start) n_state = sknsi_pkg::S_PROBE;
            sknsi_pkg::S_PROBE: n_state = search_end ?
                ((r_cmd == sknsi_pkg::CmdInsert && r_count < CW'(MAX_ENTRIES)) ?
                    ((r_count > CW'(r_lo - 1'b1)) ? sknsi_pkg::S_SRD : sknsi_pkg::S_PLACE)
                    : sknsi_pkg::S_DONE)
                : sknsi_pkg::S_CMP;
            sknsi_pkg::S_CMP:   n_state = cmp.eq ?
                ((r_cmd == sknsi_pkg::CmdInsert) ? sknsi_pkg::S_PLACE : sknsi_pkg::S_DONE)
                : sknsi_pkg::S_PROBE;
            sknsi_pkg::S_SRD:   n_state = sknsi_pkg::S_SWR;
            sknsi_pkg::S_SWR:   n_state = (r_ptr - 1'b1 == CW'(r_lo - 1'b1)) ?
                sknsi_pkg::S_PLACE : sknsi_pkg::S_SRD;
            sknsi_pkg::S_PLACE: n_state = sknsi_pkg::S_DONE;
            sknsi_pkg::S_DONE:  n_state = sknsi_pkg::S_IDLE;
            default:            n_state = sknsi_pkg::S_IDLE;
        endcase
    end

    // outputs: RAM port, search bounds
    always_comb begin
        n_lo = r_lo; n_hi = r_hi;
        we = 1'b0; waddr = '0; wkey = r_key; wlen = r_len; wval = r_val;
        raddr = AW'(mid - 1'b1);
        unique case (r_state)
            sknsi_pkg::S_IDLE: if (i_start) begin
                n_lo = PW'(1);
                n_hi = PW'(r_count);
            end
            sknsi_pkg::S_CMP: if (!cmp.eq) begin
                if (cmp.lt) n_lo = mid + 1'b1;
                else        n_hi = mid - 1'b1;
            end else n_lo = mid;
            sknsi_pkg::S_SRD: raddr = AW'(r_ptr - 1'b1);
            sknsi_pkg::S_SWR: begin
                we = 1'b1; waddr = AW'(r_ptr);
                wkey = rkey; wlen = rlen; wval = rval;
            end
            sknsi_pkg::S_PLACE: begin
                we = 1'b1; waddr = AW'(r_lo - 1'b1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sknsi_pkg::S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lo <= n_lo; r_hi <= n_hi;
            r_done <= (r_state == sknsi_pkg::S_DONE);
            unique case (r_state)
                sknsi_pkg::S_IDLE: if (i_start) begin
                    r_cmd <= i_command;
                    r_len <= len_sat;
                    r_key <= i_key_bytes & sknsi_pkg::prefix_mask(len_sat);
                    r_val <= i_new_value;
                    r_found <= 1'b0;
                    r_ptr <= r_count;
                end
                sknsi_pkg::S_CMP: if (cmp.eq) begin
                    r_found <= 1'b1;
                    if (r_cmd == sknsi_pkg::CmdFind) r_val <= rval;
                end
                sknsi_pkg::S_SWR: r_ptr <= r_ptr - 1'b1;
                sknsi_pkg::S_PLACE: if (!r_found) r_count <= r_count + 1'b1;
                sknsi_pkg::S_DONE: begin
                    o_found <= r_found;
                    o_entry_index <= 7'(r_lo - 1'b1);
                    o_stored_value <= (r_found && r_cmd == sknsi_pkg::CmdFind) ? r_val : '0;
                    o_status <= (!r_found && r_cmd == sknsi_pkg::CmdInsert &&
                        r_count >= CW'(MAX_ENTRIES) && r_state == sknsi_pkg::S_DONE &&
                        r_ptr == r_count) ? sknsi_pkg::StatFull : sknsi_pkg::StatOk;
                end
                default: ;
            endcase
        end
    end

    assign o_busy = (r_state != sknsi_pkg::S_IDLE);
    assign o_done = r_done;
endmodule

// ===== rtl/core/sknsi_checker.sv =====
`include "assert_macros.svh"
module sknsi_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done,
    input logic o_found,
    input logic o_status
);
    `ASSERT_NEXT(a_start_busy, i_start && !o_busy, o_busy, "busy not raised after start")
    `ASSERT_IMPL(a_done_idle, o_done, !o_busy, "done while busy")
    `ASSERT_NEXT(a_done_pulse, o_done, !o_done, "done longer than one cycle")
    `ASSERT_IMPL(a_full_nf, o_done && o_status, !o_found, "full status on a found key")
endmodule

bind sorted_key_node_search_insert sknsi_checker u_sknsi_checker (
    .i_clk, .i_rst_n, .i_start, .o_busy, .o_done, .o_found, .o_status);
